@@ src/spg_pkg.sv @@
`timescale 1ns / 1ps

package spg_pkg;

   // shared restoring divider: remainder width, quotient width, step counter width
   localparam int DIV_W  = 36;
   localparam int QUO_W  = 20;
   localparam int STEP_W = 5;

   typedef struct packed {
      logic              start;
      logic [DIV_W-1:0]  num;
      logic [DIV_W-1:0]  dsh;    // divisor already shifted left by steps - 1
      logic [STEP_W-1:0] steps;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [QUO_W-1:0] quo;
      logic [DIV_W-1:0] rem;
   } div_rsp_type;

endpackage

@@ src/spg_div.sv @@
`timescale 1ns / 1ps

module spg_div (
   input  logic                clock,
   input  logic                reset,
   input  spg_pkg::div_req_type req,
   output spg_pkg::div_rsp_type rsp
);

   logic [spg_pkg::DIV_W-1:0]  rem_ff, rem_in;
   logic [spg_pkg::DIV_W-1:0]  dsh_ff, dsh_in;
   logic [spg_pkg::QUO_W-1:0]  quo_ff, quo_in;
   logic [spg_pkg::STEP_W-1:0] cnt_ff, cnt_in;
   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic                       ge;

   assign ge = rem_ff >= dsh_ff;

   always_comb begin
      rem_in  = rem_ff;
      dsh_in  = dsh_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (req.start) begin
         rem_in  = req.num;
         dsh_in  = req.dsh;
         quo_in  = '0;
         cnt_in  = req.steps;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // one quotient bit per cycle
         if (ge) begin
            rem_in = rem_ff - dsh_ff;
         end
         quo_in = {quo_ff[spg_pkg::QUO_W-2:0], ge};
         dsh_in = dsh_ff >> 1;
         cnt_in = cnt_ff - spg_pkg::STEP_W'(1);
         if (cnt_ff == spg_pkg::STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      quo_ff <= quo_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign rsp.done = done_ff;
   assign rsp.quo  = quo_ff;
   assign rsp.rem  = rem_ff;

endmodule

@@ src/stepper_position_pulse_generator.sv @@
`timescale 1ns / 1ps

// Step/direction pulse generator.
// Input items (req_): kind 0 is one microsecond tick, kind 1 sets a target angle in
// centidegrees and a rate in steps per second (rate 0 keeps the old interval).
// Every item gives exactly one result item (rsp_): step and direction pin levels,
// position within one revolution and a moving flag, after the item is applied.
// Registers (csr_): index 0 run enable, 1 counts per revolution, 2 pulse width in
// ticks; csr_ready is always high. Write them only while the block is idle.
// A tick item is handled in the accept cycle and its result is valid the next cycle.
// A set-target item runs through one shared restoring divider, one quotient bit per
// cycle: angle reduction, a registered multiply, rounding division and, for a nonzero
// rate, the interval division. Its result is registered when the last division ends.
// One item is worked at a time; req_ready is low while the divider sequence runs or
// while a result waits on a stalled receiver and is not taken in the same cycle.
// Reset: run disabled, 3200 counts per revolution, 2 tick pulse, interval 5000,
// position and target zero, no step in progress.

module stepper_position_pulse_generator (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_kind,
   input  logic signed [23:0] req_target_angle,
   input  logic [15:0]        req_rate_sps,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_step_level,
   output logic               rsp_dir_level,
   output logic [15:0]        rsp_position,
   output logic               rsp_moving,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_data
);

   localparam logic       KIND_TICK      = 1'b0;
   localparam logic [1:0] CSR_RUN_ENABLE = 2'd0;
   localparam logic [1:0] CSR_COUNTS_REV = 2'd1;
   localparam logic [1:0] CSR_PULSE      = 2'd2;

   // multiple of 36000 that makes any 24-bit angle non-negative
   localparam logic [24:0] ANGLE_OFFSET = 25'd8424000;
   localparam logic [spg_pkg::DIV_W-1:0] MOD_DSH    = 36'd9216000;    // 36000 << 8
   localparam logic [spg_pkg::DIV_W-1:0] ROUND_BIAS = 36'd36000;
   localparam logic [spg_pkg::DIV_W-1:0] ROUND_DSH  = 36'd2359296000; // 72000 << 15
   localparam logic [spg_pkg::DIV_W-1:0] TICKS_SEC  = 36'd1000000;
   localparam logic [spg_pkg::STEP_W-1:0] MOD_STEPS   = 5'd9;
   localparam logic [spg_pkg::STEP_W-1:0] ROUND_STEPS = 5'd16;
   localparam logic [spg_pkg::STEP_W-1:0] RATE_STEPS  = 5'd20;

   typedef enum logic [2:0] {
      SEQ_IDLE, SEQ_MOD, SEQ_MUL, SEQ_DIV, SEQ_RATE
   } seq_type;

   typedef enum logic [1:0] {
      PH_IDLE, PH_HIGH, PH_LOW
   } phase_type;

   seq_type     seq_ff, seq_in;
   phase_type   phase_ff, phase_in;
   logic        run_ff, run_in;
   logic [15:0] cpr_ff, cpr_in;
   logic [9:0]  pulse_ff, pulse_in;
   logic [15:0] pos_ff, pos_in;
   logic [15:0] tgt_ff, tgt_in;
   logic [19:0] interval_ff, interval_in;
   logic [19:0] pcnt_ff, pcnt_in;
   logic        dir_ff, dir_in;
   logic [15:0] rate_ff, rate_in;
   logic [31:0] prod_ff, prod_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_step_ff, rsp_step_in;
   logic        rsp_dir_ff, rsp_dir_in;
   logic [15:0] rsp_pos_ff, rsp_pos_in;
   logic        rsp_moving_ff, rsp_moving_in;

   logic        accept;
   logic        fin;
   logic [9:0]  width_m1;
   logic [24:0] angle_u;

   spg_pkg::div_req_type div_req;
   spg_pkg::div_rsp_type div_rsp;

   spg_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign req_ready = (seq_ff == SEQ_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign width_m1  = (pulse_ff == 10'd0) ? 10'd0 : pulse_ff - 10'd1;
   assign angle_u   = {req_target_angle[23], req_target_angle} + ANGLE_OFFSET;

   always_comb begin
      seq_in      = seq_ff;
      phase_in    = phase_ff;
      run_in      = run_ff;
      cpr_in      = cpr_ff;
      pulse_in    = pulse_ff;
      pos_in      = pos_ff;
      tgt_in      = tgt_ff;
      interval_in = interval_ff;
      pcnt_in     = pcnt_ff;
      dir_in      = dir_ff;
      rate_in     = rate_ff;
      prod_in     = prod_ff;
      fin         = 1'b0;

      div_req.start = 1'b0;
      div_req.num   = '0;
      div_req.dsh   = '0;
      div_req.steps = '0;

      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_step_in   = rsp_step_ff;
      rsp_dir_in    = rsp_dir_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_moving_in = rsp_moving_ff;

      if (csr_valid) begin
         unique case (csr_index)
            CSR_RUN_ENABLE: run_in   = csr_data[0];
            CSR_COUNTS_REV: cpr_in   = csr_data;
            CSR_PULSE:      pulse_in = csr_data[9:0];
            default: ;
         endcase
      end

      unique case (seq_ff)
         SEQ_IDLE: begin
            if (accept) begin
               if (req_kind == KIND_TICK) begin
                  fin = 1'b1;
                  unique case (phase_ff)
                     PH_HIGH: begin
                        if (pcnt_ff != 20'd0) begin
                           pcnt_in = pcnt_ff - 20'd1;
                        end else begin
                           pos_in   = dir_ff ? pos_ff + 16'd1 : pos_ff - 16'd1;
                           pcnt_in  = interval_ff;
                           phase_in = (interval_ff == 20'd0) ? PH_IDLE : PH_LOW;
                        end
                     end
                     PH_LOW: begin
                        if (pcnt_ff != 20'd0) begin
                           pcnt_in = pcnt_ff - 20'd1;
                        end
                        if (pcnt_ff <= 20'd1) begin
                           phase_in = PH_IDLE;
                        end
                     end
                     PH_IDLE: begin
                        if (run_ff && pos_ff != tgt_ff) begin
                           dir_in   = tgt_ff > pos_ff;
                           phase_in = PH_HIGH;
                           pcnt_in  = {10'd0, width_m1};
                        end
                     end
                     default: phase_in = PH_IDLE;
                  endcase
               end else if (cpr_ff == 16'd0) begin
                  fin = 1'b1;
               end else begin
                  rate_in       = req_rate_sps;
                  div_req.start = 1'b1;
                  div_req.num   = {11'd0, angle_u};
                  div_req.dsh   = MOD_DSH;
                  div_req.steps = MOD_STEPS;
                  seq_in        = SEQ_MOD;
               end
            end
         end
         SEQ_MOD: begin
            if (div_rsp.done) begin
               prod_in = {16'd0, div_rsp.rem[15:0]} * {16'd0, cpr_ff};
               seq_in  = SEQ_MUL;
            end
         end
         SEQ_MUL: begin
            div_req.start = 1'b1;
            div_req.num   = {3'd0, prod_ff, 1'b0} + ROUND_BIAS;
            div_req.dsh   = ROUND_DSH;
            div_req.steps = ROUND_STEPS;
            seq_in        = SEQ_DIV;
         end
         SEQ_DIV: begin
            if (div_rsp.done) begin
               tgt_in = div_rsp.quo[15:0];
               if (rate_ff != 16'd0) begin
                  div_req.start = 1'b1;
                  div_req.num   = TICKS_SEC;
                  div_req.dsh   = {1'b0, rate_ff, 19'd0};
                  div_req.steps = RATE_STEPS;
                  seq_in        = SEQ_RATE;
               end else begin
                  fin    = 1'b1;
                  seq_in = SEQ_IDLE;
               end
            end
         end
         SEQ_RATE: begin
            if (div_rsp.done) begin
               interval_in = div_rsp.quo;
               fin         = 1'b1;
               seq_in      = SEQ_IDLE;
            end
         end
         default: seq_in = SEQ_IDLE;
      endcase

      // result item shows the state after the item is applied
      if (fin) begin
         rsp_valid_in  = 1'b1;
         rsp_step_in   = phase_in == PH_HIGH;
         rsp_dir_in    = dir_in;
         rsp_pos_in    = pos_in;
         rsp_moving_in = (pos_in != tgt_in) || (phase_in != PH_IDLE);
      end
   end

   always_ff @(posedge clock) begin
      rate_ff       <= rate_in;
      prod_ff       <= prod_in;
      rsp_step_ff   <= rsp_step_in;
      rsp_dir_ff    <= rsp_dir_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_moving_ff <= rsp_moving_in;
      if (reset) begin
         seq_ff       <= SEQ_IDLE;
         phase_ff     <= PH_IDLE;
         run_ff       <= 1'b0;
         cpr_ff       <= 16'd3200;
         pulse_ff     <= 10'd2;
         pos_ff       <= '0;
         tgt_ff       <= '0;
         interval_ff  <= 20'd5000;
         pcnt_ff      <= '0;
         dir_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         seq_ff       <= seq_in;
         phase_ff     <= phase_in;
         run_ff       <= run_in;
         cpr_ff       <= cpr_in;
         pulse_ff     <= pulse_in;
         pos_ff       <= pos_in;
         tgt_ff       <= tgt_in;
         interval_ff  <= interval_in;
         pcnt_ff      <= pcnt_in;
         dir_ff       <= dir_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_step_level = rsp_step_ff;
   assign rsp_dir_level  = rsp_dir_ff;
   assign rsp_position   = rsp_pos_ff;
   assign rsp_moving     = rsp_moving_ff;

endmodule
